FILE: hdl/sdit_pkg.sv
package sdit_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int COEF_BITS_DEF  = 32;
  localparam int FIELD_BITS     = 16;
  localparam int FRAC_BITS      = 4;
  localparam int DIST_BITS      = 24;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 64;
  localparam int THR_RESET      = 256;

  localparam logic [CFG_IDX_BITS-1:0] REG_ROW1_A = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROW1_B = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROW2   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROW3   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_LAST   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_THRESH = 3'd5;

  localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

endpackage

FILE: hdl/sampson_distance_inlier_test.sv
// Pipeline: coefficient products, epipolar lines, residual products, partial squares,
// denominator sum, square root and divider (one result bit per stage each), output register.
// Throughput: one correspondence per cycle; a stalled output freezes the whole pipeline.
// Reset: asynchronous, active low; clears the valid bits and the configuration
// registers (coefficients to zero, inlier threshold to 256).
module sampson_distance_inlier_test #(
  parameter int COORD_BITS = sdit_pkg::COORD_BITS_DEF,
  parameter int COEF_BITS  = sdit_pkg::COEF_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // left_x[15:0], left_y[31:16], right_x[47:32], right_y[63:48]
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // distance[23:0], zero fill [31:24]
  output logic [31:0] m_axis_tdata,
  // inlier[0]
  output logic        m_axis_tuser,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [sdit_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [sdit_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);

  localparam int FB   = sdit_pkg::FIELD_BITS;
  localparam int CIN  = (COORD_BITS < FB) ? COORD_BITS : FB;
  localparam int DB   = sdit_pkg::DIST_BITS;
  localparam int PW   = COEF_BITS + COORD_BITS + 1;
  localparam int LW   = PW + 2;
  localparam int QW   = LW + COORD_BITS + 1;
  localparam int NW   = QW + 2;
  localparam int BW   = NW + sdit_pkg::FRAC_BITS;
  localparam int MW   = LW;
  localparam int H    = (MW + 1) / 2;
  localparam int HW   = MW - H;
  localparam int DNW  = 2 * MW + 2;
  localparam int RW   = MW + 1;
  localparam int CW   = RW + DB + BW;
  localparam int NST  = RW + DB + 7;

  // Configuration registers.
  logic [63:0]   row1a_q, row1b_q, row2_q, row3_q;
  logic [31:0]   last_q;
  logic [DB-1:0] thr_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row1a_q <= '0;
      row1b_q <= '0;
      row2_q  <= '0;
      row3_q  <= '0;
      last_q  <= '0;
      thr_q   <= DB'(sdit_pkg::THR_RESET);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        sdit_pkg::REG_ROW1_A: row1a_q <= cfg_data_i;
        sdit_pkg::REG_ROW1_B: row1b_q <= cfg_data_i;
        sdit_pkg::REG_ROW2:   row2_q  <= cfg_data_i;
        sdit_pkg::REG_ROW3:   row3_q  <= cfg_data_i;
        sdit_pkg::REG_LAST:   last_q  <= cfg_data_i[31:0];
        sdit_pkg::REG_THRESH: thr_q   <= cfg_data_i[DB-1:0];
        default: ;
      endcase
    end
  end

  logic signed [COEF_BITS-1:0] f11, f12, f13, f21, f22, f23, f31, f32, f33;
  assign f11 = row1a_q[32 +: COEF_BITS];
  assign f12 = row1a_q[0  +: COEF_BITS];
  assign f13 = row1b_q[32 +: COEF_BITS];
  assign f21 = row1b_q[0  +: COEF_BITS];
  assign f22 = row2_q[32 +: COEF_BITS];
  assign f23 = row2_q[0  +: COEF_BITS];
  assign f31 = row3_q[32 +: COEF_BITS];
  assign f32 = row3_q[0  +: COEF_BITS];
  assign f33 = last_q[0 +: COEF_BITS];

  // Global advance: the pipeline moves unless a finished result is held.
  logic en;
  logic [NST-1:0] vld_q;
  assign en            = !vld_q[NST-1] || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], s_axis_tvalid};
    end
  end

  // Stage 1: coefficient by coordinate products.
  logic signed [COORD_BITS:0] xl_s, yl_s, xr_s, yr_s;
  assign xl_s = $signed({1'b0, COORD_BITS'(s_axis_tdata[0*FB +: CIN])});
  assign yl_s = $signed({1'b0, COORD_BITS'(s_axis_tdata[1*FB +: CIN])});
  assign xr_s = $signed({1'b0, COORD_BITS'(s_axis_tdata[2*FB +: CIN])});
  assign yr_s = $signed({1'b0, COORD_BITS'(s_axis_tdata[3*FB +: CIN])});

  logic signed [PW-1:0] p_a_q, p_b_q, p_c_q, p_d_q, p_e_q, p_f_q, p_g_q, p_h_q;
  logic signed [PW-1:0] p_i_q, p_j_q;
  logic signed [PW-1:0] p_13_q, p_23_q, p_33_q, p_31_q, p_32_q;
  logic [COORD_BITS-1:0] xr1_q, yr1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_a_q  <= PW'(f11) * PW'(xl_s);
      p_b_q  <= PW'(f12) * PW'(yl_s);
      p_c_q  <= PW'(f21) * PW'(xl_s);
      p_d_q  <= PW'(f22) * PW'(yl_s);
      p_e_q  <= PW'(f31) * PW'(xl_s);
      p_f_q  <= PW'(f32) * PW'(yl_s);
      p_g_q  <= PW'(f11) * PW'(xr_s);
      p_h_q  <= PW'(f21) * PW'(yr_s);
      p_i_q  <= PW'(f12) * PW'(xr_s);
      p_j_q  <= PW'(f22) * PW'(yr_s);
      p_13_q <= PW'(f13) <<< sdit_pkg::FRAC_BITS;
      p_23_q <= PW'(f23) <<< sdit_pkg::FRAC_BITS;
      p_33_q <= PW'(f33) <<< sdit_pkg::FRAC_BITS;
      p_31_q <= PW'(f31) <<< sdit_pkg::FRAC_BITS;
      p_32_q <= PW'(f32) <<< sdit_pkg::FRAC_BITS;
      xr1_q  <= COORD_BITS'(s_axis_tdata[2*FB +: CIN]);
      yr1_q  <= COORD_BITS'(s_axis_tdata[3*FB +: CIN]);
    end
  end

  // Stage 2: epipolar line components.
  logic signed [LW-1:0] lr0_q, lr1_q, lr2_q, ll0_q, ll1_q;
  logic [COORD_BITS-1:0] xr2_q, yr2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      lr0_q <= LW'(p_a_q) + LW'(p_b_q) + LW'(p_13_q);
      lr1_q <= LW'(p_c_q) + LW'(p_d_q) + LW'(p_23_q);
      lr2_q <= LW'(p_e_q) + LW'(p_f_q) + LW'(p_33_q);
      ll0_q <= LW'(p_g_q) + LW'(p_h_q) + LW'(p_31_q);
      ll1_q <= LW'(p_i_q) + LW'(p_j_q) + LW'(p_32_q);
      xr2_q <= xr1_q;
      yr2_q <= yr1_q;
    end
  end

  // Stage 3: residual products and gradient magnitudes.
  logic signed [QW-1:0] q0_q, q1_q, q2_q;
  logic [MW-1:0] a0_q, a1_q, a2_q, a3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      q0_q <= QW'(lr0_q) * QW'($signed({1'b0, xr2_q}));
      q1_q <= QW'(lr1_q) * QW'($signed({1'b0, yr2_q}));
      q2_q <= QW'(lr2_q) <<< sdit_pkg::FRAC_BITS;
      a0_q <= lr0_q[LW-1] ? MW'(-lr0_q) : MW'(lr0_q);
      a1_q <= lr1_q[LW-1] ? MW'(-lr1_q) : MW'(lr1_q);
      a2_q <= ll0_q[LW-1] ? MW'(-ll0_q) : MW'(ll0_q);
      a3_q <= ll1_q[LW-1] ? MW'(-ll1_q) : MW'(ll1_q);
    end
  end

  // Stage 4: residual magnitude and partial products of the squares.
  logic signed [NW-1:0] num;
  assign num = NW'(q0_q) + NW'(q1_q) + NW'(q2_q);

  logic [BW-1:0] big4_q;
  logic          nz4_q;
  logic [2*HW-1:0] hh_q [4];
  logic [MW-1:0]   hl_q [4];
  logic [2*H-1:0]  ll_q [4];
  logic [MW-1:0]   am [4];
  assign am[0] = a0_q;
  assign am[1] = a1_q;
  assign am[2] = a2_q;
  assign am[3] = a3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      big4_q <= (num[NW-1] ? BW'(-num) : BW'(num)) << sdit_pkg::FRAC_BITS;
      nz4_q  <= (num == '0);
      for (int i = 0; i < 4; i++) begin
        hh_q[i] <= am[i][MW-1:H] * am[i][MW-1:H];
        hl_q[i] <= MW'(am[i][MW-1:H]) * MW'(am[i][H-1:0]);
        ll_q[i] <= am[i][H-1:0] * am[i][H-1:0];
      end
    end
  end

  logic [DNW-1:0] sqv [4];
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sqv[i] = (DNW'(hh_q[i]) << (2 * H)) + (DNW'(hl_q[i]) << (H + 1)) + DNW'(ll_q[i]);
    end
  end

  // Square root, one result bit per stage; index 0 holds the denominator.
  logic [DNW-1:0] sq_rem_q  [RW+1];
  logic [RW-1:0]  sq_root_q [RW+1];
  logic [BW-1:0]  sq_big_q  [RW+1];
  logic           sq_nz_q   [RW+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_rem_q[0]  <= sqv[0] + sqv[1] + sqv[2] + sqv[3];
      sq_root_q[0] <= '0;
      sq_big_q[0]  <= big4_q;
      sq_nz_q[0]   <= nz4_q;
    end
  end

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    localparam int B = RW - 1 - k;
    logic [DNW-1:0] trial;
    assign trial = (DNW'(sq_root_q[k]) << (B + 1)) | (DNW'(1) << (2 * B));
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (trial <= sq_rem_q[k]) begin
          sq_rem_q[k+1]  <= sq_rem_q[k] - trial;
          sq_root_q[k+1] <= sq_root_q[k] | (RW'(1) << B);
        end else begin
          sq_rem_q[k+1]  <= sq_rem_q[k];
          sq_root_q[k+1] <= sq_root_q[k];
        end
        sq_big_q[k+1] <= sq_big_q[RW == 0 ? 0 : k];
        sq_nz_q[k+1]  <= sq_nz_q[k];
      end
    end
  end

  // Divider: saturation check, then one quotient bit per stage.
  logic [BW-1:0] dv_rem_q  [DB+1];
  logic [RW-1:0] dv_r_q    [DB+1];
  logic [DB-1:0] dv_q_q    [DB+1];
  logic          dv_done_q [DB+1];

  logic [RW-1:0] root_f;
  logic [BW-1:0] big_f;
  assign root_f = sq_root_q[RW];
  assign big_f  = sq_big_q[RW];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_rem_q[0] <= big_f;
      dv_r_q[0]   <= root_f;
      if (root_f == '0) begin
        // Zero gradient: only a zero residual gives distance zero.
        dv_done_q[0] <= 1'b1;
        dv_q_q[0]    <= sq_nz_q[RW] ? '0 : sdit_pkg::DIST_MAX;
      end else if ((CW'(root_f) << DB) <= CW'(big_f)) begin
        dv_done_q[0] <= 1'b1;
        dv_q_q[0]    <= sdit_pkg::DIST_MAX;
      end else begin
        dv_done_q[0] <= 1'b0;
        dv_q_q[0]    <= '0;
      end
    end
  end

  for (genvar j = 0; j < DB; j++) begin : g_div
    localparam int B = DB - 1 - j;
    logic [CW-1:0] trial;
    assign trial = CW'(dv_r_q[j]) << B;
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (!dv_done_q[j] && (trial <= CW'(dv_rem_q[j]))) begin
          dv_rem_q[j+1] <= dv_rem_q[j] - trial[BW-1:0];
          dv_q_q[j+1]   <= dv_q_q[j] | (DB'(1) << B);
        end else begin
          dv_rem_q[j+1] <= dv_rem_q[j];
          dv_q_q[j+1]   <= dv_q_q[j];
        end
        dv_r_q[j+1]    <= dv_r_q[j];
        dv_done_q[j+1] <= dv_done_q[j];
      end
    end
  end

  // Output register.
  logic [DB-1:0] dist_q;
  logic          inl_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_q <= dv_q_q[DB];
      inl_q  <= dv_q_q[DB] < thr_q;
    end
  end

  assign m_axis_tvalid = vld_q[NST-1];
  assign m_axis_tdata  = {(32 - DB)'(0), dist_q};
  assign m_axis_tuser  = inl_q;

endmodule

FILE: hdl/sdit_checker.sv
module sdit_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // A result that waits is kept until it is taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("held result changed");

  // Input is taken whenever the output side is free.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output state");

  // A saturated distance is never an inlier.
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[sdit_pkg::DIST_BITS-1:0] == sdit_pkg::DIST_MAX)
    |-> !m_axis_tuser)
    else $error("saturated distance flagged as inlier");

  // The fill bits above the distance stay zero.
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[31:sdit_pkg::DIST_BITS] == '0))
    else $error("nonzero fill bits");

endmodule

bind sampson_distance_inlier_test sdit_checker u_sdit_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

FILE: tb/testbench.sv
module testbench;

  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 120;
  // Indexes past the last register, written to check that they are ignored.
  localparam logic [sdit_pkg::CFG_IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [sdit_pkg::CFG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [15:0] right_y;
    logic [15:0] right_x;
    logic [15:0] left_y;
    logic [15:0] left_x;
  } pair_t;

  typedef struct {
    logic [sdit_pkg::DIST_BITS-1:0] distance;
    logic                           inlier;
  } verdict_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [sdit_pkg::CFG_IDX_BITS-1:0]  cfg_index_i = '0;
  logic [sdit_pkg::CFG_DATA_BITS-1:0] cfg_data_i = '0;

  sampson_distance_inlier_test dut (.*);

  always #5 clk_i = ~clk_i;

  // Shadow copy of the coefficient and threshold registers.
  logic [63:0] f_row1a, f_row1b, f_row2, f_row3;
  logic [31:0] f_last;
  logic [sdit_pkg::DIST_BITS-1:0] thresh;

  verdict_t pending[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int sent = 0, received = 0, inliers = 0, saturated = 0;

  function automatic verdict_t sampson(input pair_t p);
    longint f11, f12, f13, f21, f22, f23, f31, f32, f33;
    longint xl, yl, xr, yr;
    logic signed [127:0] lr0, lr1, lr2, ll0, ll1, num;
    logic [127:0] big, den, sq;
    logic [63:0] root, trial;
    verdict_t v;
    f11 = longint'($signed(f_row1a[63:32]));
    f12 = longint'($signed(f_row1a[31:0]));
    f13 = longint'($signed(f_row1b[63:32]));
    f21 = longint'($signed(f_row1b[31:0]));
    f22 = longint'($signed(f_row2[63:32]));
    f23 = longint'($signed(f_row2[31:0]));
    f31 = longint'($signed(f_row3[63:32]));
    f32 = longint'($signed(f_row3[31:0]));
    f33 = longint'($signed(f_last));
    xl = longint'(p.left_x);
    yl = longint'(p.left_y);
    xr = longint'(p.right_x);
    yr = longint'(p.right_y);
    lr0 = f11 * xl + f12 * yl + f13 * 16;
    lr1 = f21 * xl + f22 * yl + f23 * 16;
    lr2 = f31 * xl + f32 * yl + f33 * 16;
    ll0 = f11 * xr + f21 * yr + f31 * 16;
    ll1 = f12 * xr + f22 * yr + f32 * 16;
    num = lr0 * xr + lr1 * yr + lr2 * 16;
    big = (num < 0) ? -num : num;
    big = big << 4;
    den = lr0 * lr0 + lr1 * lr1 + ll0 * ll0 + ll1 * ll1;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      sq = {64'd0, trial};
      if (sq * sq <= den) root = trial;
    end
    if (root == 0) begin
      v.distance = (big == 0) ? '0 : sdit_pkg::DIST_MAX;
    end else if (({64'd0, root} << sdit_pkg::DIST_BITS) <= big) begin
      v.distance = sdit_pkg::DIST_MAX;
    end else begin
      v.distance = sdit_pkg::DIST_BITS'(big / {64'd0, root});
    end
    v.inlier = (v.distance < thresh);
    return v;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
  endtask

  // Result checking and output back-pressure.
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      received++;
      if (pending.size() == 0) begin
        report("unexpected result distance", m_axis_tdata[sdit_pkg::DIST_BITS-1:0], 0);
      end else begin
        want = pending.pop_front();
        if (m_axis_tdata[sdit_pkg::DIST_BITS-1:0] !== want.distance)
          report("distance", m_axis_tdata[sdit_pkg::DIST_BITS-1:0], want.distance);
        if (m_axis_tdata[31:sdit_pkg::DIST_BITS] !== '0)
          report("fill bits", m_axis_tdata[31:sdit_pkg::DIST_BITS], 0);
        if (m_axis_tuser !== want.inlier)
          report("inlier", m_axis_tuser, want.inlier);
        if (want.inlier) inliers++;
        if (want.distance == sdit_pkg::DIST_MAX) saturated++;
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no request accepted for %0d cycles", IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_pair(input pair_t p);
    verdict_t v;
    v = sampson(p);
    if (!s_axis_tvalid) s_axis_tvalid <= 1'b1;
    s_axis_tdata <= p;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending.insert(pending.size(), v);
    sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  // Stops the stream, waits for every outstanding result and lets the pipeline settle.
  task automatic drain;
    if (s_axis_tvalid) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    while (pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [sdit_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      sdit_pkg::REG_ROW1_A: f_row1a = val;
      sdit_pkg::REG_ROW1_B: f_row1b = val;
      sdit_pkg::REG_ROW2:   f_row2 = val;
      sdit_pkg::REG_ROW3:   f_row3 = val;
      sdit_pkg::REG_LAST:   f_last = val[31:0];
      sdit_pkg::REG_THRESH: thresh = val[sdit_pkg::DIST_BITS-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic load_matrix(input logic [31:0] f[9],
                             input logic [sdit_pkg::DIST_BITS-1:0] thr);
    write_reg(sdit_pkg::REG_ROW1_A, {f[0], f[1]});
    write_reg(sdit_pkg::REG_ROW1_B, {f[2], f[3]});
    write_reg(sdit_pkg::REG_ROW2, {f[4], f[5]});
    write_reg(sdit_pkg::REG_ROW3, {f[6], f[7]});
    write_reg(sdit_pkg::REG_LAST, {$urandom(), f[8]});
    write_reg(sdit_pkg::REG_THRESH, {$urandom(), 8'($urandom()), thr});
  endtask

  function automatic pair_t make_pair(input logic [15:0] lx, ly, rx, ry);
    pair_t p;
    p.left_x = lx;
    p.left_y = ly;
    p.right_x = rx;
    p.right_y = ry;
    return p;
  endfunction

  // A rectified stereo rig: the distance is roughly the vertical disparity over sqrt(2).
  task automatic rectified(input logic [31:0] k, input int noise,
                           input logic [sdit_pkg::DIST_BITS-1:0] thr);
    logic [31:0] f[9];
    for (int i = 0; i < 9; i++) f[i] = 32'($signed($urandom_range(2 * noise)) - noise);
    f[5] = -k;
    f[7] = k;
    load_matrix(f, thr);
  endtask

  task automatic test_reset_values;
    f_row1a = '0; f_row1b = '0; f_row2 = '0; f_row3 = '0; f_last = '0;
    thresh = sdit_pkg::DIST_BITS'(sdit_pkg::THR_RESET);
    send_pair(make_pair(16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_pair(make_pair(16'hffff, 16'hffff, 16'hffff, 16'hffff));
    send_pair(make_pair(16'h1234, 16'hfedc, 16'h0001, 16'h8000));
    drain();
  endtask

  task automatic test_directed;
    logic [31:0] f[9];
    // Only the constant term is set, so the gradient vanishes and the residual does not.
    f = '{default: 32'd0};
    f[8] = 32'h4000_0000;
    load_matrix(f, sdit_pkg::DIST_MAX);
    send_pair(make_pair(16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_pair(make_pair(16'hffff, 16'h0000, 16'h0000, 16'hffff));
    drain();
    rectified(32'h4000_0000, 0, 24'd256);
    send_pair(make_pair(16'h0100, 16'h0200, 16'h0080, 16'h0200));
    send_pair(make_pair(16'h0100, 16'h0200, 16'h0080, 16'h0210));
    send_pair(make_pair(16'h0100, 16'h0210, 16'h0080, 16'h0200));
    send_pair(make_pair(16'h0000, 16'h0000, 16'hffff, 16'hffff));
    send_pair(make_pair(16'hffff, 16'hffff, 16'h0000, 16'h0000));
    send_pair(make_pair(16'hffff, 16'hffff, 16'hffff, 16'hffff));
    drain();
    // Coefficients at both ends of their range with extreme coordinates.
    f = '{default: 32'h8000_0000};
    f[1] = 32'h7fff_ffff;
    f[4] = 32'h7fff_ffff;
    load_matrix(f, 24'd0);
    write_reg(REG_SPARE_LO, {$urandom(), $urandom()});
    write_reg(REG_SPARE_HI, {$urandom(), $urandom()});
    send_pair(make_pair(16'hffff, 16'hffff, 16'hffff, 16'hffff));
    send_pair(make_pair(16'hffff, 16'h0000, 16'h0000, 16'hffff));
    send_pair(make_pair(16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_pair(make_pair(16'h8000, 16'h7fff, 16'h0001, 16'hfffe));
    f = '{default: 32'h7fff_ffff};
    drain();
    load_matrix(f, sdit_pkg::DIST_MAX);
    send_pair(make_pair(16'hffff, 16'hffff, 16'hffff, 16'hffff));
    send_pair(make_pair(16'h0001, 16'h0002, 16'h0003, 16'h0004));
    drain();
  endtask

  task automatic random_setting;
    logic [31:0] f[9];
    logic [sdit_pkg::DIST_BITS-1:0] thr;
    int pick;
    case ($urandom_range(3))
      0: thr = 24'd0;
      1: thr = sdit_pkg::DIST_MAX;
      2: thr = 24'($urandom_range(64, 1024));
      default: thr = 24'($urandom());
    endcase
    pick = $urandom_range(9);
    if (pick < 6) begin
      rectified(32'($urandom_range(32'h7fff_ffff, 32'h0010_0000)), $urandom_range(4096), thr);
    end else begin
      for (int i = 0; i < 9; i++) begin
        if (pick == 9) f[i] = $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
        else f[i] = $urandom() >> $urandom_range(31);
      end
      load_matrix(f, thr);
    end
  endtask

  task automatic test_random(input int s_idle, input int r_idle, input int count);
    logic [15:0] ly, ry;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int n = 0; n < count; n++) begin
      if (n % 110 == 0) begin
        drain();
        random_setting();
      end
      ly = 16'($urandom());
      if ($urandom_range(9) < 8) ry = ly + 16'($signed($urandom_range(64)) - 32);
      else ry = 16'($urandom());
      send_pair(make_pair(16'($urandom()), ly, 16'($urandom()), ry));
    end
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_directed();
    test_random(28, 47, 330);
    test_random(47, 28, 330);
    test_random(0, 0, 330);
    $display("Sent %0d correspondences over reset, directed and random matrix settings;",
             sent);
    $display("%0d results checked, %0d inliers, %0d saturated distances.",
             received, inliers, saturated);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
